[sv/mie_pkg.sv]
// Shared types and constants for the modular inverse block.
// No dependencies; imported by the controller, the datapath, the top level, the checker and the bench.
package mie_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] word_t;

    localparam word_t RESET_MODULUS = DATA_W'(8380417);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_RED_END,
        OP_STEP_START,
        OP_STEP_END,
        OP_FIX,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic m_zero;
        logic r1_zero;
        logic div_last;
    } dp_status_t;

endpackage

[sv/mie_dp.sv]
// Datapath of the modular inverse block: modulus register, bit-serial divider with
// shift-add coefficient update, Euclid registers and result registers.
// Depends on mie_pkg.
module mie_dp
    import mie_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_op_t     op,
    input  logic       cfg_we,
    input  word_t      cfg_data,
    input  word_t      operand,
    output dp_status_t status,
    output word_t      inv_value,
    output logic       inv_exists
);

    word_t              modulus_reg, modulus_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    word_t              r0_reg, r0_next;
    word_t              r1_reg, r1_next;
    word_t              div_reg, div_next;
    word_t              quo_reg, quo_next;
    word_t              rem_reg, rem_next;
    word_t              acc_reg, acc_next;
    word_t              mag0_reg, mag0_next;
    word_t              mag1_reg, mag1_next;
    logic               neg0_reg, neg0_next;
    logic               neg1_reg, neg1_next;
    word_t              inv_value_reg, inv_value_next;
    logic               inv_exists_reg, inv_exists_next;

    logic [DATA_W:0]    trial_sh;
    logic [DATA_W:0]    trial_sub;
    logic               q_bit;
    logic               ok;

    assign trial_sh  = {rem_reg, quo_reg[DATA_W-1]};
    assign trial_sub = trial_sh - {1'b0, div_reg};
    assign q_bit     = ~trial_sub[DATA_W];
    assign ok        = (r0_reg == DATA_W'(1)) && (modulus_reg != '0);

    always_comb
    begin
        modulus_next    = cfg_we ? cfg_data : modulus_reg;
        cnt_next        = cnt_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        acc_next        = acc_reg;
        mag0_next       = mag0_reg;
        mag1_next       = mag1_reg;
        neg0_next       = neg0_reg;
        neg1_next       = neg1_reg;
        inv_value_next  = inv_value_reg;
        inv_exists_next = inv_exists_reg;
        unique case (op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                r0_next   = modulus_reg;
                div_next  = modulus_reg;
                quo_next  = operand;
                rem_next  = '0;
                acc_next  = '0;
                cnt_next  = '0;
                mag0_next = '0;
                mag1_next = DATA_W'(1);
                neg0_next = 1'b0;
                neg1_next = 1'b0;
            end
            OP_DIV:
            begin
                quo_next = {quo_reg[DATA_W-2:0], q_bit};
                rem_next = q_bit ? trial_sub[DATA_W-1:0] : trial_sh[DATA_W-1:0];
                acc_next = {acc_reg[DATA_W-2:0], 1'b0} + (q_bit ? mag1_reg : '0);
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_RED_END:
            begin
                r1_next = rem_reg;
            end
            OP_STEP_START:
            begin
                div_next = r1_reg;
                quo_next = r0_reg;
                rem_next = '0;
                acc_next = '0;
                cnt_next = '0;
            end
            OP_STEP_END:
            begin
                r0_next   = r1_reg;
                r1_next   = rem_reg;
                mag0_next = mag1_reg;
                mag1_next = mag0_reg + acc_reg;
                neg0_next = neg1_reg;
                neg1_next = ~neg1_reg;
            end
            OP_FIX:
            begin
                if (mag0_reg >= modulus_reg)
                begin
                    mag0_next = mag0_reg - modulus_reg;
                end
            end
            OP_FINISH:
            begin
                inv_exists_next = ok;
                if (!ok)
                begin
                    inv_value_next = '0;
                end
                else if (neg0_reg && (mag0_reg != '0))
                begin
                    inv_value_next = modulus_reg - mag0_reg;
                end
                else
                begin
                    inv_value_next = mag0_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= RESET_MODULUS;
            cnt_reg     <= '0;
        end
        else
        begin
            modulus_reg <= modulus_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg         <= r0_next;
        r1_reg         <= r1_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        acc_reg        <= acc_next;
        mag0_reg       <= mag0_next;
        mag1_reg       <= mag1_next;
        neg0_reg       <= neg0_next;
        neg1_reg       <= neg1_next;
        inv_value_reg  <= inv_value_next;
        inv_exists_reg <= inv_exists_next;
    end

    assign status.m_zero   = (modulus_reg == '0);
    assign status.r1_zero  = (r1_reg == '0);
    assign status.div_last = (cnt_reg == CNT_W'(DATA_W - 1));
    assign inv_value       = inv_value_reg;
    assign inv_exists      = inv_exists_reg;

endmodule

[sv/mie_ctrl.sv]
// Controller of the modular inverse block: sequences reduction, Euclid steps and
// the final correction, and owns the input and output handshakes. Depends on mie_pkg.
module mie_ctrl
    import mie_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_RED_END,
        S_CHECK,
        S_DIV,
        S_STEP_END,
        S_FIX,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = ~(out_valid_reg & out_stall);

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NONE;
        out_valid_next = out_valid_reg & out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                op = OP_DIV;
                if (status.div_last)
                begin
                    state_next = S_RED_END;
                end
            end
            S_RED_END:
            begin
                op         = OP_RED_END;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.r1_zero || status.m_zero)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    op         = OP_STEP_START;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                op = OP_DIV;
                if (status.div_last)
                begin
                    state_next = S_STEP_END;
                end
            end
            S_STEP_END:
            begin
                op         = OP_STEP_END;
                state_next = S_CHECK;
            end
            S_FIX:
            begin
                op         = OP_FIX;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    op             = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[sv/modular_inverse_euclid_top.sv]
// Modular inverse by the extended Euclidean algorithm, one operand at a time. An operand
// is first reduced modulo the modulus and then runs the quotient steps of the Euclid
// remainder sequence (at most 45 for 32-bit values); every step runs one bit-serial
// division in the shared divider followed by an update of the Euclid and coefficient
// registers. A new operand is taken once the previous
// one has finished, while its result may still be waiting in the output register.
// Depends on mie_pkg, mie_ctrl and mie_dp.
module modular_inverse_euclid_top
    import mie_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_valid,
    output logic  cfg_ready,
    input  word_t modulus,
    input  logic  in_valid,
    output logic  in_stall,
    input  word_t operand_value,
    output logic  out_valid,
    input  logic  out_stall,
    output word_t inverse_value,
    output logic  inverse_exists
);

    dp_op_t     op;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .op        (op)
    );

    mie_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_data   (modulus),
        .operand    (operand_value),
        .status     (status),
        .inv_value  (inverse_value),
        .inv_exists (inverse_exists)
    );

endmodule

[sv/mie_chk.sv]
// Port-level checker for the modular inverse block, bound to the top level.
// Depends on mie_pkg and modular_inverse_euclid_top.
module mie_chk
    import mie_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_stall,
    input logic  out_valid,
    input logic  out_stall,
    input word_t inverse_value,
    input logic  inverse_exists
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inverse_value)
            && $stable(inverse_exists))
        else $error("Stalled result changed before its transfer.");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inverse_exists |-> inverse_value == '0)
        else $error("Result without an inverse carries a nonzero value.");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input was not stalled after an operand transfer.");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("Result appeared without a computation in progress.");

endmodule

bind modular_inverse_euclid_top mie_chk u_chk (.*);

[bench/testbench.sv]
// Self-checking bench for modular_inverse_euclid_top: directed operands, then random
// operands under many modulus settings with random idling, checked by an internal predictor.
// Depends on mie_pkg and the modular_inverse_euclid_top RTL.
module testbench;
    import mie_pkg::*;

    localparam int HOLD_CYCLES = 4000;
    localparam int SEGMENTS = 10;
    localparam int SEGMENT_ITEMS = 37;

    typedef struct packed {
        word_t value;
        logic  exists;
    } inv_result_t;

    typedef struct {
        bit    wr_mod;
        word_t mod_val;
        word_t operand;
        bit    typed;
        word_t inv;
        bit    ok;
    } dir_row_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_valid;
    logic  cfg_ready;
    word_t modulus;
    logic  in_valid;
    logic  in_stall;
    word_t operand_value;
    logic  out_valid;
    logic  out_stall;
    word_t inverse_value;
    logic  inverse_exists;

    inv_result_t awaited_inverses[$];
    word_t       model_modulus;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    bit          hold_request;
    int          hold_left;
    int          operand_count;
    int          result_count;
    int          modulus_writes;
    int          mismatch_count;

    modular_inverse_euclid_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .modulus        (modulus),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operand_value  (operand_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .inverse_value  (inverse_value),
        .inverse_exists (inverse_exists)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic inv_result_t compute_inverse(word_t m, word_t a);
        word_t               r0;
        word_t               r1;
        word_t               rn;
        word_t               q;
        logic [2*DATA_W-1:0] mag0;
        logic [2*DATA_W-1:0] mag1;
        logic [2*DATA_W-1:0] mn;
        logic                neg0;
        logic                neg1;
        inv_result_t         res;
        res.value  = '0;
        res.exists = 1'b0;
        if (m == '0)
            return res;
        r0   = m;
        r1   = a % m;
        mag0 = '0;
        neg0 = 1'b0;
        mag1 = 1;
        neg1 = 1'b0;
        for (int i = 0; i < 2 * DATA_W + 2 && r1 != '0; i++)
        begin
            q    = r0 / r1;
            rn   = r0 - q * r1;
            r0   = r1;
            r1   = rn;
            mn   = mag0 + q * mag1;
            mag0 = mag1;
            neg0 = neg1;
            mag1 = mn;
            neg1 = ~neg1;
        end
        if (r0 != 1)
            return res;
        mag0 = mag0 % m;
        if (neg0 && mag0 != '0)
            mag0 = m - mag0;
        res.value  = mag0[DATA_W-1:0];
        res.exists = 1'b1;
        return res;
    endfunction

    function automatic word_t pick_modulus();
        word_t v;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(64, 1);
            2: v = 32'd1 << $urandom_range(31, 0);
            3: v = '1;
            default: v = $urandom & ~32'd1;
        endcase
        if (v == '0)
            v = 32'd2;
        return v;
    endfunction

    function automatic word_t pick_operand(word_t m);
        word_t v;
        case ($urandom_range(9))
            5: v = $urandom_range(15, 0);
            6: v = m - $urandom_range(3, 0);
            7: v = m * $urandom_range(5, 1);
            8: v = m + $urandom_range(3, 0);
            9: v = '1 - $urandom_range(3, 0);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_operand(input word_t v, input bit typed, input inv_result_t typed_res);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        operand_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        awaited_inverses.push_back(typed ? typed_res : compute_inverse(model_modulus, v));
        operand_count++;
        @(negedge clk);
    endtask

    // The block is drained before the register is written.
    task automatic set_modulus(input word_t v);
        in_valid <= 1'b0;
        while (awaited_inverses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        modulus   <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_modulus = v;
        modulus_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (awaited_inverses.size() == 0)
                begin
                    report_mismatch("unexpected result", inverse_value, '0);
                end
                else
                begin
                    if (inverse_value !== awaited_inverses[0].value)
                        report_mismatch("inverse_value", inverse_value,
                                        awaited_inverses[0].value);
                    if (inverse_exists !== awaited_inverses[0].exists)
                        report_mismatch("inverse_exists", word_t'(inverse_exists),
                                        word_t'(awaited_inverses[0].exists));
                    void'(awaited_inverses.pop_front());
                    result_count++;
                end
            end
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        dir_row_t    plan [0:24];
        inv_result_t want;
        int          wait_left;
        plan = '{
            '{1'b0, 32'd0,          32'd0,          1'b1, 32'd0,          1'b0},
            '{1'b0, 32'd0,          32'd1,          1'b1, 32'd1,          1'b1},
            '{1'b0, 32'd0,          32'd8380417,    1'b1, 32'd0,          1'b0},
            '{1'b0, 32'd0,          32'd8380416,    1'b1, 32'd8380416,    1'b1},
            '{1'b0, 32'd0,          32'd8380418,    1'b1, 32'd1,          1'b1},
            '{1'b0, 32'd0,          32'd2,          1'b1, 32'd4190209,    1'b1},
            '{1'b0, 32'd0,          32'hFFFFFFFF,   1'b0, 32'd0,          1'b0},
            '{1'b1, 32'd1,          32'd0,          1'b1, 32'd0,          1'b1},
            '{1'b0, 32'd0,          32'hFFFFFFFF,   1'b1, 32'd0,          1'b1},
            '{1'b0, 32'd0,          32'd12345,      1'b1, 32'd0,          1'b1},
            '{1'b1, 32'hFFFFFFFF,   32'd0,          1'b1, 32'd0,          1'b0},
            '{1'b0, 32'd0,          32'hFFFFFFFF,   1'b1, 32'd0,          1'b0},
            '{1'b0, 32'd0,          32'hFFFFFFFE,   1'b1, 32'hFFFFFFFE,   1'b1},
            '{1'b0, 32'd0,          32'd1,          1'b1, 32'd1,          1'b1},
            '{1'b0, 32'd0,          32'd3,          1'b1, 32'd0,          1'b0},
            '{1'b0, 32'd0,          32'd2,          1'b1, 32'h80000000,   1'b1},
            '{1'b0, 32'd0,          32'h12345678,   1'b0, 32'd0,          1'b0},
            '{1'b1, 32'd2,          32'd1,          1'b1, 32'd1,          1'b1},
            '{1'b0, 32'd0,          32'd0,          1'b1, 32'd0,          1'b0},
            '{1'b0, 32'd0,          32'hFFFFFFFF,   1'b1, 32'd1,          1'b1},
            '{1'b0, 32'd0,          32'hFFFFFFFE,   1'b1, 32'd0,          1'b0},
            '{1'b1, 32'hFFFFFFFB,   32'hFFFFFFFF,   1'b0, 32'd0,          1'b0},
            '{1'b0, 32'd0,          32'h80000000,   1'b0, 32'd0,          1'b0},
            '{1'b0, 32'd0,          32'hFFFFFFFB,   1'b1, 32'd0,          1'b0},
            '{1'b1, 32'd2971215073, 32'd1836311903, 1'b0, 32'd0,          1'b0}
        };
        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        modulus           = RESET_MODULUS;
        in_valid          = 1'b0;
        operand_value     = '0;
        model_modulus     = RESET_MODULUS;
        hold_request      = 1'b0;
        operand_count     = 0;
        result_count      = 0;
        modulus_writes    = 0;
        mismatch_count    = 0;
        sender_idle_pct   = 20;
        receiver_idle_pct = 55;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].wr_mod)
                set_modulus(plan[i].mod_val);
            want.value  = plan[i].inv;
            want.exists = plan[i].ok;
            send_operand(plan[i].operand, plan[i].typed, want);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 4)
            begin
                sender_idle_pct   = 20;
                receiver_idle_pct = 55;
            end
            else if (seg < 7)
            begin
                sender_idle_pct   = 55;
                receiver_idle_pct = 20;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            set_modulus(pick_modulus());
            if (seg == 7)
                hold_request = 1'b1;
            repeat (SEGMENT_ITEMS)
                send_operand(pick_operand(model_modulus), 1'b0, '0);
        end
        in_valid <= 1'b0;

        wait_left = 2 * HOLD_CYCLES;
        while (awaited_inverses.size() != 0 && wait_left > 0)
        begin
            @(posedge clk);
            wait_left--;
        end
        repeat (50) @(posedge clk);
        if (awaited_inverses.size() != 0)
            report_mismatch("results never delivered", word_t'(awaited_inverses.size()), '0);

        $display("Sent %0d operands across %0d modulus settings and compared %0d results.",
                 operand_count, modulus_writes + 1, result_count);
        $display("Both sides idled at random, and the output was held for %0d cycles once.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
